>>> rtl/next_fit_address_allocator_top_macros.svh
// assertion helpers for the address allocator
`ifndef NEXT_FIT_ADDRESS_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_ADDRESS_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define NFAA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define NFAA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/nfaa_pkg.sv
`default_nettype none

package nfaa_pkg;

	localparam int NUM_SLOTS_DEF = 256;
	localparam int ROW_BITS      = 8;
	localparam int FIRST_HOST    = 2;
	localparam int HOST_SHIFT    = 24;
	localparam int PREFIX_W      = 24;
	localparam int ADDR_W        = 32;
	localparam int HOST_W        = ADDR_W - HOST_SHIFT;
	localparam logic [PREFIX_W-1:0] PREFIX_RESET = 24'h1CA8C0;

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_CLAIM   = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_IN_USE    = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

endpackage

`default_nettype wire

>>> rtl/next_fit_address_allocator_top.sv
// Next-fit host address allocator for one /24 pool. Requests are taken one at a time: in_stall
// stays high from the accepting edge until the result has been taken. An allocate scans the
// in-use map one 8-slot row per cycle through a single row port, starting at the candidate's row
// and coming back to it once more, so it visits 1 to ceil(NUMBER_SLOTS/8)+1 rows (1 to 33 at
// 256 slots) and then presents the result. Claim and release each access the map once and then
// present the result; an invalid or unknown request goes straight to the result.
// An allocate only proposes an address and does not mark it used; a later claim marks it.
// base_prefix may be written at any time the block is idle, cfg_ready is always high.
`default_nettype none

module next_fit_address_allocator_top import nfaa_pkg::*; #(
	parameter int NUMBER_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [PREFIX_W-1:0] base_prefix,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          kind,
	input  wire logic [ADDR_W-1:0]   address,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [ADDR_W-1:0]        assigned_address,
	output logic [1:0]               status
);

	localparam int ROWS  = (NUMBER_SLOTS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W = $clog2(ROWS);
	localparam int BIT_W = $clog2(ROW_BITS);
	localparam int IDX_W = ROW_W + BIT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CLAIM,
		S_RELEASE,
		S_DONE
	} state_t;

	function automatic logic [ROW_BITS-1:0] reset_row(input int r);
		logic [ROW_BITS-1:0] v;
		int                  idx;
		v = '0;
		for (int b = 0; b < ROW_BITS; b++) begin
			idx = r * ROW_BITS + b;
			if (idx < FIRST_HOST || idx == NUMBER_SLOTS - 1)
				v[b] = 1'b1;
		end
		return v;
	endfunction

	state_t                 state_q;
	logic [ROW_BITS-1:0]    map_q [ROWS];
	logic [PREFIX_W-1:0]    prefix_q;
	logic [ROW_W-1:0]       row_q;
	logic [BIT_W-1:0]       bit_q;
	logic [ROW_W:0]         steps_q;
	logic [IDX_W-1:0]       cand_q;
	logic [ADDR_W-1:0]      res_addr_q;
	status_t                res_status_q;

	logic [HOST_W-1:0]      host_in;
	logic                   host_beyond;
	logic                   host_rel_ok;
	logic [ROW_BITS-1:0]    row_data;
	logic [ROW_BITS-1:0]    row_used;
	logic [ROW_BITS-1:0]    row_free;
	logic                   found;
	logic [BIT_W-1:0]       pick;
	logic [IDX_W-1:0]       grant;
	logic [IDX_W:0]         grant_inc;
	logic [IDX_W-1:0]       cand_nxt;
	logic                   last_visit;
	logic [ROW_W-1:0]       row_nxt;
	logic                   map_we;
	logic                   map_wbit;

	assign host_in     = address[ADDR_W-1:HOST_SHIFT];
	assign host_beyond = {1'b0, host_in} >= (HOST_W + 1)'(NUMBER_SLOTS);
	assign host_rel_ok = ({1'b0, host_in} >= (HOST_W + 1)'(FIRST_HOST)) &&
		({1'b0, host_in} < (HOST_W + 1)'(NUMBER_SLOTS - 1));

	assign row_data = map_q[row_q];

	// slots past the end of the map count as used
	always_comb begin
		row_used = row_data;
		for (int b = 0; b < ROW_BITS; b++) begin
			if ({1'b0, row_q, BIT_W'(b)} >= (IDX_W + 1)'(NUMBER_SLOTS))
				row_used[b] = 1'b1;
		end
		row_free = ~row_used;
		if (steps_q == '0)
			row_free = row_free & (ROW_BITS'({ROW_BITS{1'b1}}) << bit_q);
	end

	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (row_free[b]) begin
				found = 1'b1;
				pick  = BIT_W'(b);
			end
		end
	end

	assign grant      = {row_q, pick};
	assign grant_inc  = {1'b0, grant} + (IDX_W + 1)'(1);
	assign cand_nxt   = (grant_inc == (IDX_W + 1)'(NUMBER_SLOTS - 1)) ? '0 : grant_inc[IDX_W-1:0];
	assign last_visit = steps_q == (ROW_W + 1)'(ROWS);
	assign row_nxt    = (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + ROW_W'(1);

	assign map_we   = (state_q == S_RELEASE) || ((state_q == S_CLAIM) && !row_data[bit_q]);
	assign map_wbit = state_q == S_CLAIM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				map_q[r] <= reset_row(r);
		end else if (map_we) begin
			map_q[row_q][bit_q] <= map_wbit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PREFIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			prefix_q <= base_prefix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cand_q       <= IDX_W'(FIRST_HOST);
			row_q        <= '0;
			bit_q        <= '0;
			steps_q      <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_addr_q <= '0;
						steps_q    <= '0;
						case (kind)
							KIND_ALLOC: begin
								row_q   <= cand_q[IDX_W-1:BIT_W];
								bit_q   <= cand_q[BIT_W-1:0];
								state_q <= S_SCAN;
							end
							KIND_CLAIM: begin
								row_q <= host_in[IDX_W-1:BIT_W];
								bit_q <= host_in[BIT_W-1:0];
								if (host_beyond) begin
									res_status_q <= ST_INVALID;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_CLAIM;
								end
							end
							KIND_RELEASE: begin
								row_q <= host_in[IDX_W-1:BIT_W];
								bit_q <= host_in[BIT_W-1:0];
								if (host_rel_ok) begin
									state_q <= S_RELEASE;
								end else begin
									res_status_q <= ST_INVALID;
									state_q      <= S_DONE;
								end
							end
							default: begin
								res_status_q <= ST_INVALID;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (found) begin
						res_addr_q   <= {HOST_W'(grant), prefix_q};
						res_status_q <= ST_OK;
						cand_q       <= cand_nxt;
						state_q      <= S_DONE;
					end else if (last_visit) begin
						res_status_q <= ST_EXHAUSTED;
						state_q      <= S_DONE;
					end else begin
						row_q   <= row_nxt;
						steps_q <= steps_q + (ROW_W + 1)'(1);
					end
				end
				S_CLAIM: begin
					res_status_q <= row_data[bit_q] ? ST_IN_USE : ST_OK;
					state_q      <= S_DONE;
				end
				S_RELEASE: begin
					res_status_q <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready        = 1'b1;
	assign in_stall         = state_q != S_IDLE;
	assign out_valid        = state_q == S_DONE;
	assign assigned_address = res_addr_q;
	assign status           = res_status_q;

endmodule

`default_nettype wire

>>> rtl/nfaa_checker.sv
`default_nettype none

`include "next_fit_address_allocator_top_macros.svh"

module nfaa_checker import nfaa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [ADDR_W-1:0] assigned_address,
	input wire logic [1:0]        status
)
;

	// stalled result holds
	`NFAA_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && out_stall, out_valid && $stable(assigned_address) && $stable(status), "stalled result changed")

	// only a granted allocate carries an address
	`NFAA_ASSERT_NOW(a_addr_only_ok, clk, arst_n, out_valid && (status != ST_OK), assigned_address == '0, "address on a failed request")

	// one request in flight at a time
	`NFAA_ASSERT_NOW(a_busy_with_result, clk, arst_n, out_valid, in_stall, "new request taken while a result waits")

	`NFAA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "not busy after accepting a request")

	`NFAA_ASSERT_NEXT(a_single_result, clk, arst_n, out_valid && !out_stall, !out_valid, "result repeated")

endmodule

bind next_fit_address_allocator_top nfaa_checker u_nfaa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.assigned_address (assigned_address),
	.status           (status)
);

`default_nettype wire
